// File: sv/trl_pkg.sv
// package for the three-anchor planar trilateration unit
// shared constants, width helpers and the control struct; no dependencies
package trl_pkg;

   localparam int COORD_BITS_DEF = 20;
   localparam int RANGE_BITS     = 20;
   localparam int DZ_BITS        = 21;
   localparam int RHO_BITS       = 2 * DZ_BITS;
   localparam int SPLIT_BITS     = 32;

   typedef struct packed {
      logic valid;
      logic neg_x;
      logic neg_y;
      logic singular;
   } ctl_type;

   function automatic int e_bits(input int c);
      return ((RHO_BITS > 2 * c + 1) ? RHO_BITS : 2 * c + 1) + 1;
   endfunction

   function automatic int b_bits(input int c);
      return e_bits(c) + 1;
   endfunction

   function automatic int n_bits(input int c);
      return b_bits(c) + c + 2;
   endfunction

endpackage

// File: sv/trl_prep.sv
// front stages: squared ranges, planar projection, row differences and det products
// depends on trl_pkg
module trl_prep #(
   parameter int COORD_BITS = trl_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [COORD_BITS-1:0]         x0, y0, x1, y1, x2, y2,
   input  logic [trl_pkg::RANGE_BITS-1:0]       r0, r1, r2,
   input  logic signed [trl_pkg::DZ_BITS-1:0]   z0, z1, z2,
   output logic                                 out_valid,
   output logic signed [trl_pkg::b_bits(COORD_BITS)-1:0] b1, b2,
   output logic signed [COORD_BITS:0]           d11, d12, d21, d22,
   output logic signed [2*COORD_BITS+1:0]       p1, p2
);

   localparam int C   = COORD_BITS;
   localparam int SQW = 2 * C + 1;
   localparam int RW  = trl_pkg::RHO_BITS;
   localparam int EW  = trl_pkg::e_bits(C);
   localparam int BW  = trl_pkg::b_bits(C);
   localparam int PW  = 2 * C + 2;
   localparam int RRW = 2 * trl_pkg::RANGE_BITS;

   logic signed [C-1:0]                  px [3];
   logic signed [C-1:0]                  py [3];
   logic [trl_pkg::RANGE_BITS-1:0]       rg [3];
   logic signed [trl_pkg::DZ_BITS-1:0]   dz [3];

   logic signed [RW-1:0]  rho_in [3];
   logic signed [RW-1:0]  rho_ff [3];
   logic signed [SQW-1:0] sq_in [3];
   logic signed [SQW-1:0] sq_ff [3];
   logic signed [C:0]     d11_in, d12_in, d21_in, d22_in;
   logic signed [C:0]     d11_ff, d12_ff, d21_ff, d22_ff;
   logic signed [C:0]     d11_2_ff, d12_2_ff, d21_2_ff, d22_2_ff;
   logic                  v1_ff, v2_ff;

   logic signed [EW-1:0]  e [3];
   logic signed [BW-1:0]  b1_in, b2_in, b1_ff, b2_ff;
   logic signed [PW-1:0]  p1_in, p2_in, p1_ff, p2_ff;

   assign px = '{x0, x1, x2};
   assign py = '{y0, y1, y2};
   assign rg = '{r0, r1, r2};
   assign dz = '{z0, z1, z2};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [RRW-1:0]       rx;
         logic signed [RW-1:0] zx;
         logic signed [SQW-1:0] xx, yx;
         rx = RRW'(rg[i]);
         zx = RW'(dz[i]);
         xx = SQW'(px[i]);
         yx = SQW'(py[i]);
         rho_in[i] = $signed({2'b00, rx * rx}) - zx * zx;
         sq_in[i]  = xx * xx + yx * yx;
      end
   end

   assign d11_in = (C+1)'(px[1]) - (C+1)'(px[0]);
   assign d12_in = (C+1)'(py[1]) - (C+1)'(py[0]);
   assign d21_in = (C+1)'(px[2]) - (C+1)'(px[1]);
   assign d22_in = (C+1)'(py[2]) - (C+1)'(py[1]);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e[i] = EW'(rho_ff[i]) - EW'(sq_ff[i]);
      end
   end

   assign b1_in = BW'(e[0]) - BW'(e[1]);
   assign b2_in = BW'(e[1]) - BW'(e[2]);
   assign p1_in = PW'(d11_ff) * PW'(d22_ff);
   assign p2_in = PW'(d12_ff) * PW'(d21_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      rho_ff   <= rho_in;
      sq_ff    <= sq_in;
      d11_ff   <= d11_in;
      d12_ff   <= d12_in;
      d21_ff   <= d21_in;
      d22_ff   <= d22_in;
      b1_ff    <= b1_in;
      b2_ff    <= b2_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      d11_2_ff <= d11_ff;
      d12_2_ff <= d12_ff;
      d21_2_ff <= d21_ff;
      d22_2_ff <= d22_ff;
   end

   assign out_valid = v2_ff;
   assign b1  = b1_ff;
   assign b2  = b2_ff;
   assign p1  = p1_ff;
   assign p2  = p2_ff;
   assign d11 = d11_2_ff;
   assign d12 = d12_2_ff;
   assign d21 = d21_2_ff;
   assign d22 = d22_2_ff;

endmodule

// File: sv/trl_numer.sv
// middle stages: determinant, split numerator products, magnitudes and signs
// depends on trl_pkg
module trl_numer #(
   parameter int COORD_BITS = trl_pkg::COORD_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic signed [trl_pkg::b_bits(COORD_BITS)-1:0] b1, b2,
   input  logic signed [COORD_BITS:0]                    d11, d12, d21, d22,
   input  logic signed [2*COORD_BITS+1:0]                p1, p2,
   output trl_pkg::ctl_type                              ctl,
   output logic [trl_pkg::n_bits(COORD_BITS):0]          num_x, num_y,
   output logic [2*COORD_BITS+3:0]                       den
);

   localparam int C   = COORD_BITS;
   localparam int BW  = trl_pkg::b_bits(C);
   localparam int NW  = trl_pkg::n_bits(C);
   localparam int SB  = trl_pkg::SPLIT_BITS;
   localparam int HW  = BW - SB;
   localparam int HPW = HW + C + 1;
   localparam int LPW = SB + 1 + C + 1;
   localparam int DW  = 2 * C + 3;

   logic signed [HW-1:0]  b1h, b2h;
   logic signed [SB:0]    b1l, b2l;
   logic signed [HPW-1:0] hx1_ff, hx2_ff, hy1_ff, hy2_ff;
   logic signed [LPW-1:0] lx1_ff, lx2_ff, ly1_ff, ly2_ff;
   logic signed [DW-1:0]  det_in, det_ff, det2_ff;
   logic                  v3_ff, v4_ff;

   logic signed [HPW:0]   hx, hy;
   logic signed [LPW:0]   lx, ly;
   logic signed [NW-1:0]  nx_in, ny_in, nx_ff, ny_ff;

   logic [NW-1:0]         ax, ay;
   logic [DW-1:0]         ad;
   trl_pkg::ctl_type      ctl_in, ctl_ff;
   logic [NW:0]           numx_ff, numy_ff;
   logic [DW:0]           den_ff;

   assign b1h = b1[BW-1:SB];
   assign b2h = b2[BW-1:SB];
   assign b1l = $signed({1'b0, b1[SB-1:0]});
   assign b2l = $signed({1'b0, b2[SB-1:0]});
   assign det_in = DW'(p1) - DW'(p2);

   always_ff @(posedge clock) begin
      hx1_ff <= HPW'(b1h) * HPW'(d22);
      hx2_ff <= HPW'(b2h) * HPW'(d12);
      hy1_ff <= HPW'(b2h) * HPW'(d11);
      hy2_ff <= HPW'(b1h) * HPW'(d21);
      lx1_ff <= LPW'(b1l) * LPW'(d22);
      lx2_ff <= LPW'(b2l) * LPW'(d12);
      ly1_ff <= LPW'(b2l) * LPW'(d11);
      ly2_ff <= LPW'(b1l) * LPW'(d21);
      det_ff <= det_in;
   end

   assign hx = (HPW+1)'(hx1_ff) - (HPW+1)'(hx2_ff);
   assign hy = (HPW+1)'(hy1_ff) - (HPW+1)'(hy2_ff);
   assign lx = (LPW+1)'(lx1_ff) - (LPW+1)'(lx2_ff);
   assign ly = (LPW+1)'(ly1_ff) - (LPW+1)'(ly2_ff);
   assign nx_in = (NW'(hx) <<< SB) + NW'(lx);
   assign ny_in = (NW'(hy) <<< SB) + NW'(ly);

   always_ff @(posedge clock) begin
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      det2_ff <= det_ff;
   end

   assign ax = nx_ff[NW-1] ? NW'(-nx_ff) : NW'(nx_ff);
   assign ay = ny_ff[NW-1] ? NW'(-ny_ff) : NW'(ny_ff);
   assign ad = det2_ff[DW-1] ? DW'(-det2_ff) : DW'(det2_ff);

   always_comb begin
      ctl_in.valid    = v4_ff;
      ctl_in.neg_x    = nx_ff[NW-1] ^ det2_ff[DW-1];
      ctl_in.neg_y    = ny_ff[NW-1] ^ det2_ff[DW-1];
      ctl_in.singular = (det2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else begin
         v3_ff        <= in_valid;
         v4_ff        <= v3_ff;
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.neg_x    <= ctl_in.neg_x;
      ctl_ff.neg_y    <= ctl_in.neg_y;
      ctl_ff.singular <= ctl_in.singular;
   end

   always_ff @(posedge clock) begin
      numx_ff <= (NW+1)'(ax) + (NW+1)'(ad);
      numy_ff <= (NW+1)'(ay) + (NW+1)'(ad);
      den_ff  <= {ad, 1'b0};
   end

   assign ctl   = ctl_ff;
   assign num_x = numx_ff;
   assign num_y = numy_ff;
   assign den   = den_ff;

endmodule

// File: sv/trl_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on trl_pkg
module trl_div #(
   parameter int COORD_BITS = trl_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic [trl_pkg::n_bits(COORD_BITS):0] num,
   input  logic [2*COORD_BITS+3:0]              den,
   output logic [COORD_BITS:0]                  quo,
   output logic                                 ovf
);

   localparam int C  = COORD_BITS;
   localparam int QW = C + 1;
   localparam int XW = trl_pkg::n_bits(C) + 1;
   localparam int DW = 2 * C + 4;

   logic [XW-1:0] rem_in [QW+1];
   logic [XW-1:0] rem_ff [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic [QW-1:0] q_in   [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic          ovf_in [QW+1];
   logic          ovf_ff [QW+1];

   assign rem_in[0] = num;
   assign q_in[0]   = '0;
   assign ovf_in[0] = (num >= (XW'(den) << QW));

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem_in[0];
      den_ff[0] <= den;
      q_ff[0]   <= q_in[0];
      ovf_ff[0] <= ovf_in[0];
   end

   for (genvar s = 1; s <= QW; s++) begin : g_stage
      logic [XW-1:0] sh;
      logic          ge;
      assign sh = XW'(den_ff[s-1]) << (QW - s);
      assign ge = (rem_ff[s-1] >= sh);
      assign rem_in[s] = ge ? rem_ff[s-1] - sh : rem_ff[s-1];
      assign q_in[s]   = q_ff[s-1] | (QW'(ge) << (QW - s));
      assign ovf_in[s] = ovf_ff[s-1];
      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in[s];
         den_ff[s] <= den_ff[s-1];
         q_ff[s]   <= q_in[s];
         ovf_ff[s] <= ovf_in[s];
      end
   end

   assign quo = q_ff[QW];
   assign ovf = ovf_ff[QW];

endmodule

// File: sv/planar_trilateration_three_anchor_unit.sv
// throughput: one beat per cycle, busy stays low; the one-bit-per-stage divider is fully pipelined
// reset: synchronous, clears all valid bits; payload registers are not reset
// the receiver cannot stall, so results are shown for exactly one cycle
// top level: front, numerator and divider stages plus saturation; depends on trl_pkg,
// trl_prep, trl_numer and trl_div
module planar_trilateration_three_anchor_unit #(
   parameter int COORD_BITS = trl_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [COORD_BITS-1:0]       req_ref_x_first,
   input  logic signed [COORD_BITS-1:0]       req_ref_y_first,
   input  logic signed [COORD_BITS-1:0]       req_ref_x_second,
   input  logic signed [COORD_BITS-1:0]       req_ref_y_second,
   input  logic signed [COORD_BITS-1:0]       req_ref_x_third,
   input  logic signed [COORD_BITS-1:0]       req_ref_y_third,
   input  logic [trl_pkg::RANGE_BITS-1:0]     req_range_first,
   input  logic [trl_pkg::RANGE_BITS-1:0]     req_range_second,
   input  logic [trl_pkg::RANGE_BITS-1:0]     req_range_third,
   input  logic signed [trl_pkg::DZ_BITS-1:0] req_dz_first,
   input  logic signed [trl_pkg::DZ_BITS-1:0] req_dz_second,
   input  logic signed [trl_pkg::DZ_BITS-1:0] req_dz_third,
   output logic                               rsp_strobe,
   output logic signed [COORD_BITS-1:0]       rsp_pos_x,
   output logic signed [COORD_BITS-1:0]       rsp_pos_y,
   output logic                               rsp_singular,
   output logic                               rsp_clipped
);

   localparam int C   = COORD_BITS;
   localparam int QW  = C + 1;
   localparam int BW  = trl_pkg::b_bits(C);
   localparam int NW  = trl_pkg::n_bits(C);
   localparam int LAT = C + 8;

   logic                 pv;
   logic signed [BW-1:0] b1, b2;
   logic signed [C:0]    d11, d12, d21, d22;
   logic signed [2*C+1:0] p1, p2;

   trl_pkg::ctl_type     nctl;
   logic [NW:0]          num_x, num_y;
   logic [2*C+3:0]       den;

   logic [QW-1:0]        qx, qy;
   logic                 ox, oy;

   trl_pkg::ctl_type     ctl_ff [QW+1];
   trl_pkg::ctl_type     ctl_last;

   logic [QW-1:0]        half, lim_x, lim_y, mag_x, mag_y;
   logic                 clip_x, clip_y;
   logic signed [C-1:0]  pos_x_in, pos_y_in, pos_x_ff, pos_y_ff;
   logic                 sing_in, clip_in, sing_ff, clip_ff, strobe_ff;

   assign busy = 1'b0;

   trl_prep #(.COORD_BITS(C)) u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .x0 (req_ref_x_first),  .y0 (req_ref_y_first),
      .x1 (req_ref_x_second), .y1 (req_ref_y_second),
      .x2 (req_ref_x_third),  .y2 (req_ref_y_third),
      .r0 (req_range_first),  .r1 (req_range_second), .r2 (req_range_third),
      .z0 (req_dz_first),     .z1 (req_dz_second),    .z2 (req_dz_third),
      .out_valid (pv),
      .b1 (b1), .b2 (b2),
      .d11 (d11), .d12 (d12), .d21 (d21), .d22 (d22),
      .p1 (p1), .p2 (p2)
   );

   trl_numer #(.COORD_BITS(C)) u_numer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pv),
      .b1 (b1), .b2 (b2),
      .d11 (d11), .d12 (d12), .d21 (d21), .d22 (d22),
      .p1 (p1), .p2 (p2),
      .ctl   (nctl),
      .num_x (num_x),
      .num_y (num_y),
      .den   (den)
   );

   trl_div #(.COORD_BITS(C)) u_div_x (
      .clock (clock), .num (num_x), .den (den), .quo (qx), .ovf (ox)
   );

   trl_div #(.COORD_BITS(C)) u_div_y (
      .clock (clock), .num (num_y), .den (den), .quo (qy), .ovf (oy)
   );

   // control travels alongside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QW; s++) begin
            ctl_ff[s].valid <= 1'b0;
         end
      end else begin
         ctl_ff[0].valid <= nctl.valid;
         for (int s = 1; s <= QW; s++) begin
            ctl_ff[s].valid <= ctl_ff[s-1].valid;
         end
      end
      ctl_ff[0].neg_x    <= nctl.neg_x;
      ctl_ff[0].neg_y    <= nctl.neg_y;
      ctl_ff[0].singular <= nctl.singular;
      for (int s = 1; s <= QW; s++) begin
         ctl_ff[s].neg_x    <= ctl_ff[s-1].neg_x;
         ctl_ff[s].neg_y    <= ctl_ff[s-1].neg_y;
         ctl_ff[s].singular <= ctl_ff[s-1].singular;
      end
   end

   assign ctl_last = ctl_ff[QW];

   // saturation to the coordinate range
   assign half   = QW'(1) << (C - 1);
   assign lim_x  = ctl_last.neg_x ? half : half - QW'(1);
   assign lim_y  = ctl_last.neg_y ? half : half - QW'(1);
   assign clip_x = ox || (qx > lim_x);
   assign clip_y = oy || (qy > lim_y);
   assign mag_x  = clip_x ? lim_x : qx;
   assign mag_y  = clip_y ? lim_y : qy;

   always_comb begin
      logic [QW-1:0] sx, sy;
      sx = ctl_last.neg_x ? QW'(0) - mag_x : mag_x;
      sy = ctl_last.neg_y ? QW'(0) - mag_y : mag_y;
      sing_in = ctl_last.singular;
      if (ctl_last.singular) begin
         pos_x_in = '0;
         pos_y_in = '0;
         clip_in  = 1'b0;
      end else begin
         pos_x_in = $signed(sx[C-1:0]);
         pos_y_in = $signed(sy[C-1:0]);
         clip_in  = clip_x || clip_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl_last.valid;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      sing_ff  <= sing_in;
      clip_ff  <= clip_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_pos_x    = pos_x_ff;
   assign rsp_pos_y    = pos_y_ff;
   assign rsp_singular = sing_ff;
   assign rsp_clipped  = clip_ff;

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LAT))
      else $error("result beat without a matching request");

   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_singular) |-> (rsp_pos_x == '0 && rsp_pos_y == '0 && !rsp_clipped))
      else $error("singular beat carries a position");

   a_pipe_valid : assert property (@(posedge clock) disable iff (reset)
      ctl_last.valid |=> rsp_strobe)
      else $error("divider output lost before the result register");
`endif

endmodule

// File: tb/sv/planar_trilateration_three_anchor_unit_tb.sv
// testbench for planar_trilateration_three_anchor_unit: directed and random ranging sets,
// each checked against an in-bench wide-integer trilateration solver
// depends on trl_pkg and the unit under test
`timescale 1ns / 1ps

module planar_trilateration_three_anchor_unit_tb;

   localparam int CW        = trl_pkg::COORD_BITS_DEF;
   localparam int RW        = trl_pkg::RANGE_BITS;
   localparam int DW        = trl_pkg::DZ_BITS;
   localparam int LATENCY   = CW + 8;
   localparam int IDLE_MAX  = 1000;
   localparam int N_RANDOM  = 1530;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [CW-1:0] x[3];
      logic signed [CW-1:0] y[3];
      logic [RW-1:0]        rng[3];
      logic signed [DW-1:0] dz[3];
   } fix_set_type;

   typedef struct {
      logic signed [CW-1:0] pos_x;
      logic signed [CW-1:0] pos_y;
      logic                 singular;
      logic                 clipped;
   } position_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic signed [CW-1:0] req_ref_x_first, req_ref_y_first;
   logic signed [CW-1:0] req_ref_x_second, req_ref_y_second;
   logic signed [CW-1:0] req_ref_x_third, req_ref_y_third;
   logic [RW-1:0]        req_range_first, req_range_second, req_range_third;
   logic signed [DW-1:0] req_dz_first, req_dz_second, req_dz_third;
   logic                 rsp_strobe;
   logic signed [CW-1:0] rsp_pos_x, rsp_pos_y;
   logic                 rsp_singular, rsp_clipped;

   position_type pending_positions[$];
   int           mismatches;
   int           idle_cycles;

   planar_trilateration_three_anchor_unit #(.COORD_BITS(CW)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ref_x_first(req_ref_x_first), .req_ref_y_first(req_ref_y_first),
      .req_ref_x_second(req_ref_x_second), .req_ref_y_second(req_ref_y_second),
      .req_ref_x_third(req_ref_x_third), .req_ref_y_third(req_ref_y_third),
      .req_range_first(req_range_first), .req_range_second(req_range_second),
      .req_range_third(req_range_third),
      .req_dz_first(req_dz_first), .req_dz_second(req_dz_second),
      .req_dz_third(req_dz_third),
      .rsp_strobe(rsp_strobe), .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_singular(rsp_singular), .rsp_clipped(rsp_clipped)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // rounded, saturated quotient n / (2 det)
   function automatic logic signed [CW-1:0] round_coord(input wide_type n,
                                                        input wide_type det,
                                                        inout logic clip);
      logic [127:0] mag_n, mag_d, quo, lim;
      logic         neg;
      mag_n = n[127] ? -n : n;
      mag_d = det[127] ? -det : det;
      quo   = (mag_n + mag_d) / (mag_d << 1);
      neg   = n[127] ^ det[127];
      lim   = neg ? (128'd1 << (CW - 1)) : (128'd1 << (CW - 1)) - 1;
      if (quo > lim) begin
         quo  = lim;
         clip = 1'b1;
      end
      return neg ? CW'(-quo) : CW'(quo);
   endfunction

   function automatic position_type solve_position(input fix_set_type f);
      position_type res;
      wide_type     e[3];
      wide_type     d11, d12, d21, d22, b1, b2, det, nx, ny;
      logic         clip;
      for (int i = 0; i < 3; i++) begin
         e[i] = wide_type'(f.rng[i]) * wide_type'(f.rng[i])
                - wide_type'(f.dz[i]) * wide_type'(f.dz[i])
                - wide_type'(f.x[i]) * wide_type'(f.x[i])
                - wide_type'(f.y[i]) * wide_type'(f.y[i]);
      end
      d11 = wide_type'(f.x[1]) - wide_type'(f.x[0]);
      d12 = wide_type'(f.y[1]) - wide_type'(f.y[0]);
      d21 = wide_type'(f.x[2]) - wide_type'(f.x[1]);
      d22 = wide_type'(f.y[2]) - wide_type'(f.y[1]);
      b1  = e[0] - e[1];
      b2  = e[1] - e[2];
      det = d11 * d22 - d12 * d21;
      res = '{pos_x: '0, pos_y: '0, singular: 1'b1, clipped: 1'b0};
      if (det != 0) begin
         clip         = 1'b0;
         nx           = b1 * d22 - b2 * d12;
         ny           = b2 * d11 - b1 * d21;
         res.pos_x    = round_coord(nx, det, clip);
         res.pos_y    = round_coord(ny, det, clip);
         res.singular = 1'b0;
         res.clipped  = clip;
      end
      return res;
   endfunction

   function automatic longint isqrt(input longint v);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v)
            r = r + (longint'(1) << b);
      end
      return r;
   endfunction

   // start stays high across back-to-back beats
   task automatic send_fix(input fix_set_type f);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_ref_x_first  <= f.x[0];
      req_ref_y_first  <= f.y[0];
      req_ref_x_second <= f.x[1];
      req_ref_y_second <= f.y[1];
      req_ref_x_third  <= f.x[2];
      req_ref_y_third  <= f.y[2];
      req_range_first  <= f.rng[0];
      req_range_second <= f.rng[1];
      req_range_third  <= f.rng[2];
      req_dz_first     <= f.dz[0];
      req_dz_second    <= f.dz[1];
      req_dz_third     <= f.dz[2];
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_positions = {pending_positions, solve_position(f)};
   endtask

   function automatic fix_set_type random_fix();
      fix_set_type f;
      for (int i = 0; i < 3; i++) begin
         f.x[i]   = CW'($urandom);
         f.y[i]   = CW'($urandom);
         f.rng[i] = RW'($urandom);
         f.dz[i]  = DW'($urandom);
      end
      return f;
   endfunction

   // consistent geometry: ranges measured from a true node position
   function automatic fix_set_type survey_fix(input int spread, input int dz_span);
      fix_set_type f;
      int          px, py, ox, oy, dz;
      longint      d;
      px = $urandom_range(0, 400000) - 200000;
      py = $urandom_range(0, 400000) - 200000;
      for (int i = 0; i < 3; i++) begin
         ox = $urandom_range(0, 2 * spread) - spread;
         oy = $urandom_range(0, 2 * spread) - spread;
         dz = $urandom_range(0, 2 * dz_span) - dz_span;
         f.x[i]  = CW'(px + ox);
         f.y[i]  = CW'(py + oy);
         f.dz[i] = DW'(dz);
         d = isqrt(longint'(ox) * ox + longint'(oy) * oy + longint'(dz) * dz)
             + $urandom_range(0, 4) - 2;
         if (d < 0) d = 0;
         if (d > (1 << RW) - 1) d = (1 << RW) - 1;
         f.rng[i] = RW'(d);
      end
      return f;
   endfunction

   task automatic test_extremes();
      fix_set_type f;
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            f.x[i]   = (k[0] ^ i[0]) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            f.y[i]   = (k[1] ^ (i == 2)) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            f.rng[i] = k[0] ? '1 : '0;
            f.dz[i]  = k[1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
         end
         send_fix(f);
      end
      // range shorter than height difference, and both zero
      f = survey_fix(1000, 0);
      f.rng[0] = 5;
      f.dz[0]  = 700000;
      f.rng[1] = 0;
      f.dz[1]  = 0;
      send_fix(f);
      // most negative dz code
      f = survey_fix(50000, 10);
      f.dz[2] = {1'b1, {(DW-1){1'b0}}};
      send_fix(f);
   endtask

   task automatic test_singular();
      fix_set_type f;
      f = survey_fix(100000, 1000);
      f.x[1] = f.x[0];
      f.y[1] = f.y[0];
      send_fix(f);
      f = survey_fix(100000, 1000);
      f.x[2] = f.x[0];
      f.y[2] = f.y[0];
      send_fix(f);
      for (int i = 0; i < 3; i++) begin
         f.x[i] = CW'(-1000 + 300 * i);
         f.y[i] = CW'(500 - 700 * i);
      end
      send_fix(f);
      f = random_fix();
      f.x[0] = 0; f.x[1] = 0; f.x[2] = 0;
      send_fix(f);
   endtask

   task automatic test_geometry();
      fix_set_type f;
      for (int k = 0; k < 8; k++) send_fix(survey_fix(300000, 50000));
      // tiny anchor triangles give halves and coarse rounding
      for (int k = 0; k < 6; k++) begin
         f = survey_fix(4, 2);
         f.rng[k % 3] = RW'($urandom_range(0, 12));
         send_fix(f);
      end
   endtask

   task automatic test_random();
      fix_set_type f;
      int          pick, a, s;
      for (int n = 0; n < N_RANDOM; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            f = survey_fix(300000, 50000);
         end else if (pick < 70) begin
            f = survey_fix($urandom_range(1, 64), $urandom_range(0, 32));
         end else if (pick < 80) begin
            f = survey_fix(300000, 50000);
            a = $urandom_range(0, 2);
            s = $urandom_range(0, 3) - 1;
            f.x[(a + 2) % 3] = f.x[a] + CW'(s) * (f.x[(a + 1) % 3] - f.x[a]);
            f.y[(a + 2) % 3] = f.y[a] + CW'(s) * (f.y[(a + 1) % 3] - f.y[a]);
         end else begin
            f = random_fix();
         end
         send_fix(f);
      end
   endtask

   always @(posedge clock) begin
      position_type want;
      if (!reset && rsp_strobe) begin
         if (pending_positions.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("unexpected beat x=%0d y=%0d", rsp_pos_x, rsp_pos_y);
         end else begin
            want = pending_positions.pop_front();
            if (rsp_pos_x !== want.pos_x || rsp_pos_y !== want.pos_y ||
                rsp_singular !== want.singular || rsp_clipped !== want.clipped) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch exp x=%0d y=%0d s=%0b c=%0b got x=%0d y=%0d s=%0b c=%0b",
                           want.pos_x, want.pos_y, want.singular, want.clipped,
                           rsp_pos_x, rsp_pos_y, rsp_singular, rsp_clipped);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("planar_trilateration_three_anchor_unit_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      mismatches       = 0;
      idle_cycles      = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_ref_x_first  = '0;
      req_ref_y_first  = '0;
      req_ref_x_second = '0;
      req_ref_y_second = '0;
      req_ref_x_third  = '0;
      req_ref_y_third  = '0;
      req_range_first  = '0;
      req_range_second = '0;
      req_range_third  = '0;
      req_dz_first     = '0;
      req_dz_second    = '0;
      req_dz_third     = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_singular();
      test_geometry();
      test_random();
      start <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && pending_positions.size() == 0) begin
         $display("planar_trilateration_three_anchor_unit_tb passed");
      end else begin
         $display("planar_trilateration_three_anchor_unit_tb failed");
      end
      $finish;
   end

endmodule
